@@ design/tmfc_pkg.sv @@
// ----------------------------------------------------------------------------
// tmfc_pkg
// Shared types and codes for the telemetry memory frame collector.
// ----------------------------------------------------------------------------
package tmfc_pkg;

  // timer
  localparam int TICK_W        = 12;
  localparam int TIMEOUT_SCALE = 10;
  localparam logic [TICK_W-1:0] TICK_MAX = '1;

  // opcodes
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_FRAME = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  // frame types
  localparam logic [2:0] FT_MEMORY  = 3'd0;
  localparam logic [2:0] FT_HS_REQ  = 3'd1;
  localparam logic [2:0] FT_MARKER  = 3'd2;
  localparam logic [2:0] FT_HS_CONF = 3'd3;

  // protocol modes
  localparam logic [1:0] MODE_TOLERANT = 2'd0;
  localparam logic [1:0] MODE_STRICT   = 2'd1;

  // completion status
  localparam logic [2:0] ST_SUCCESS     = 3'd0;
  localparam logic [2:0] ST_RX_ERROR    = 3'd1;
  localparam logic [2:0] ST_INTERRUPTED = 3'd2;
  localparam logic [2:0] ST_TIMEOUT     = 3'd3;
  localparam logic [2:0] ST_BAD_TYPE    = 3'd4;

  // configuration register indexes
  localparam logic [1:0] CFG_PROTOCOL_MODE  = 2'd0;
  localparam logic [1:0] CFG_EXPECTED_BYTES = 2'd1;
  localparam logic [1:0] CFG_TIMEOUT_LIMIT  = 2'd2;

  typedef struct packed {
    logic [1:0] opcode;
    logic [2:0] frame_type;
    logic [7:0] frame_data;
  } tmfc_in_t;

  typedef struct packed {
    logic        store_valid;
    logic [15:0] store_index;
    logic [7:0]  store_data;
    logic        done_res;
    logic [2:0]  status;
    logic [15:0] interrupt_count;
  } tmfc_out_t;

  typedef struct packed {
    logic [1:0]  protocol_mode;
    logic [15:0] expected_bytes;
    logic [7:0]  timeout_limit;
  } tmfc_cfg_t;

  typedef struct packed {
    logic              active;
    logic              first_found;
    logic [15:0]       byte_count;
    logic [TICK_W-1:0] elapsed_ticks;
    logic [15:0]       tolerated_count;
  } tmfc_state_t;

endpackage

@@ design/tmfc_step.sv @@
// ----------------------------------------------------------------------------
// tmfc_step
// Next-state and result logic for one request of the collector.
// ----------------------------------------------------------------------------
module tmfc_step
  import tmfc_pkg::*;
(
  input  tmfc_cfg_t   cfg,
  input  tmfc_state_t st,
  input  tmfc_in_t    req,
  output tmfc_state_t st_nxt,
  output tmfc_out_t   res
);

  logic [16:0]       cnt_inc;
  logic [TICK_W-1:0] tick_inc;
  logic [TICK_W-1:0] tick_limit;

  assign cnt_inc    = {1'b0, st.byte_count} + 17'd1;
  assign tick_inc   = (st.elapsed_ticks < TICK_MAX) ? st.elapsed_ticks + 1'b1
                                                    : st.elapsed_ticks;
  assign tick_limit = {{(TICK_W-8){1'b0}}, cfg.timeout_limit}
                      * TICK_W'(TIMEOUT_SCALE);

  always_comb begin
    st_nxt = st;
    res    = '0;
    case (req.opcode)
      OP_START: begin
        st_nxt.active          = 1'b1;
        st_nxt.first_found     = 1'b0;
        st_nxt.byte_count      = '0;
        st_nxt.elapsed_ticks   = '0;
        st_nxt.tolerated_count = '0;
        if (cfg.protocol_mode > MODE_STRICT) begin
          st_nxt.active = 1'b0;
          res.done_res  = 1'b1;
          res.status    = ST_BAD_TYPE;
        end else if (cfg.expected_bytes == '0) begin
          st_nxt.active = 1'b0;
          res.done_res  = 1'b1;
          res.status    = (cfg.protocol_mode == MODE_TOLERANT) ? ST_RX_ERROR
                                                                : ST_SUCCESS;
        end
      end
      OP_FRAME: begin
        if (st.active) begin
          if (req.frame_type == FT_MEMORY) begin
            st_nxt.first_found = 1'b1;
            st_nxt.byte_count  = cnt_inc[15:0];
            res.store_valid    = 1'b1;
            res.store_index    = st.byte_count;
            res.store_data     = req.frame_data;
            if (cnt_inc >= {1'b0, cfg.expected_bytes}) begin
              st_nxt.active = 1'b0;
              res.done_res  = 1'b1;
              res.status    = ST_SUCCESS;
            end
          end else if (st.first_found) begin
            if (cfg.protocol_mode == MODE_TOLERANT &&
                req.frame_type inside {FT_HS_REQ, FT_MARKER, FT_HS_CONF}) begin
              if (st.tolerated_count != '1) begin
                st_nxt.tolerated_count = st.tolerated_count + 1'b1;
              end
            end else begin
              st_nxt.active = 1'b0;
              res.done_res  = 1'b1;
              res.status    = ST_INTERRUPTED;
            end
          end
        end
      end
      OP_TICK: begin
        if (st.active) begin
          st_nxt.elapsed_ticks = tick_inc;
          if (tick_inc >= tick_limit) begin
            st_nxt.active = 1'b0;
            res.done_res  = 1'b1;
            res.status    = ST_TIMEOUT;
          end
        end
      end
      default: begin
      end
    endcase
    res.interrupt_count = st_nxt.tolerated_count;
  end

endmodule

@@ design/telemetry_memory_frame_collector.sv @@
// ----------------------------------------------------------------------------
// telemetry_memory_frame_collector
// Collects memory bytes from typed telemetry frames after a start request.
// ----------------------------------------------------------------------------
// The result of an accepted request is registered and shows in out_data in the next cycle.
// Throughput: one request per cycle; the only limit is the result register,
//   which takes a new request whenever it is empty or being drained.
// Reset (rst_n low, synchronous): collection idle, counters and config registers
//   zero, no result pending.
module telemetry_memory_frame_collector
  import tmfc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  // config write port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  // request channel
  input  logic      in_valid,
  output logic      in_stall,
  input  tmfc_in_t  in_data,
  // result channel
  output logic      out_valid,
  input  logic      out_stall,
  output tmfc_out_t out_data
);

  tmfc_cfg_t   cfg_r;
  tmfc_state_t st_r;
  tmfc_state_t st_nxt;
  tmfc_out_t   res_nxt;
  tmfc_out_t   out_data_r;
  logic        out_valid_r;
  logic        in_acc;

  // Result register holds one result; it frees up in the same cycle it is
  // taken, so a new request goes in alongside the drain.
  assign in_stall = out_valid_r & out_stall;
  assign in_acc   = in_valid & ~in_stall;

  // --- config registers ---
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PROTOCOL_MODE:  cfg_r.protocol_mode  <= cfg_wdata[1:0];
        CFG_EXPECTED_BYTES: cfg_r.expected_bytes <= cfg_wdata;
        CFG_TIMEOUT_LIMIT:  cfg_r.timeout_limit  <= cfg_wdata[7:0];
        default: begin
        end
      endcase
    end
  end

  // --- per-request update ---
  tmfc_step u_step (
    .cfg    (cfg_r),
    .st     (st_r),
    .req    (in_data),
    .st_nxt (st_nxt),
    .res    (res_nxt)
  );

  // collection state moves only on an accepted request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (in_acc) begin
      st_r <= st_nxt;
    end
  end

  // --- result register ---
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // payload: no reset needed
  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_data_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ design/tmfc_checker.sv @@
// ----------------------------------------------------------------------------
// tmfc_checker
// Port-level checks on the collector, bound to the top level.
// ----------------------------------------------------------------------------
module tmfc_checker
  import tmfc_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input tmfc_out_t out_data
);

  // held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // every accepted request yields a result next cycle
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted request produced no result");

  // status only accompanies completion
  a_status_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.done_res |-> out_data.status == ST_SUCCESS)
    else $error("status set without completion");

  // a stored byte can only finish a collection successfully
  a_store_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.store_valid |-> out_data.status == ST_SUCCESS)
    else $error("stored byte with failure status");

  // empty store slot carries zeros
  a_store_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.store_valid |->
      out_data.store_index == '0 && out_data.store_data == '0)
    else $error("store fields set without store_valid");

endmodule

bind telemetry_memory_frame_collector tmfc_checker u_tmfc_checker (.*);

@@ sim/collector_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// collector_checker
// Follows the register writes and the requests taken by the frame collector,
// works out the report that each request should give, and compares the
// reports that leave the block with them in order.
// ----------------------------------------------------------------------------
module collector_checker
  import tmfc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  input  logic        in_stall,
  input  tmfc_in_t    in_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  tmfc_out_t   out_data,
  output int          fail_count,
  output int          outstanding
);

  tmfc_cfg_t   regs;
  tmfc_state_t col;
  tmfc_out_t   predicted_reports[$];
  tmfc_out_t   want;
  int          errors = 0;

  function automatic void close_collection(inout tmfc_out_t rpt, input logic [2:0] code);
    col.active   = 1'b0;
    rpt.done_res = 1'b1;
    rpt.status   = code;
  endfunction

  function automatic tmfc_out_t predict_report(input tmfc_in_t req);
    tmfc_out_t   rpt;
    logic [16:0] emitted;
    rpt = '0;
    case (req.opcode)
      OP_START: begin
        col        = '0;
        col.active = 1'b1;
        if (regs.protocol_mode != MODE_TOLERANT && regs.protocol_mode != MODE_STRICT) begin
          close_collection(rpt, ST_BAD_TYPE);
        end else if (regs.expected_bytes == '0) begin
          close_collection(rpt, regs.protocol_mode == MODE_TOLERANT ? ST_RX_ERROR : ST_SUCCESS);
        end
      end
      OP_FRAME: begin
        if (col.active) begin
          if (req.frame_type == FT_MEMORY) begin
            col.first_found = 1'b1;
            rpt.store_valid = 1'b1;
            rpt.store_index = col.byte_count;
            rpt.store_data  = req.frame_data;
            emitted         = {1'b0, col.byte_count} + 17'd1;
            col.byte_count  = emitted[15:0];
            if (emitted >= {1'b0, regs.expected_bytes}) begin
              close_collection(rpt, ST_SUCCESS);
            end
          end else if (col.first_found) begin
            if (regs.protocol_mode == MODE_TOLERANT &&
                req.frame_type >= FT_HS_REQ && req.frame_type <= FT_HS_CONF) begin
              if (col.tolerated_count != 16'hFFFF) begin
                col.tolerated_count = col.tolerated_count + 16'd1;
              end
            end else begin
              close_collection(rpt, ST_INTERRUPTED);
            end
          end
        end
      end
      OP_TICK: begin
        if (col.active) begin
          if (col.elapsed_ticks != TICK_MAX) begin
            col.elapsed_ticks = col.elapsed_ticks + 1'b1;
          end
          if (int'(col.elapsed_ticks) >= int'(regs.timeout_limit) * TIMEOUT_SCALE) begin
            close_collection(rpt, ST_TIMEOUT);
          end
        end
      end
      default: ;
    endcase
    rpt.interrupt_count = col.tolerated_count;
    return rpt;
  endfunction

  function automatic void check_field(string field, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, exp_v, act_v);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      regs = '0;
      col  = '0;
      predicted_reports.delete();
    end else begin
      // a report taken at this edge belongs to an earlier request
      if (out_valid && !out_stall) begin
        if (predicted_reports.size() == 0) begin
          $display("%0t: unexpected report, expected none actual %p", $time, out_data);
          errors++;
        end else begin
          want = predicted_reports.pop_front();
          check_field("store_valid", want.store_valid, out_data.store_valid);
          check_field("store_index", want.store_index, out_data.store_index);
          check_field("store_data", want.store_data, out_data.store_data);
          check_field("done_res", want.done_res, out_data.done_res);
          check_field("status", want.status, out_data.status);
          check_field("interrupt_count", want.interrupt_count, out_data.interrupt_count);
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_PROTOCOL_MODE:  regs.protocol_mode  = cfg_wdata[1:0];
          CFG_EXPECTED_BYTES: regs.expected_bytes = cfg_wdata;
          CFG_TIMEOUT_LIMIT:  regs.timeout_limit  = cfg_wdata[7:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        predicted_reports.push_back(predict_report(in_data));
      end
    end
    outstanding <= predicted_reports.size();
    fail_count  <= errors;
  end

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Regression for the telemetry memory frame collector: a directed pass over
// the corner cases, then random collection sessions under three idle
// profiles, with every report checked by collector_checker.
// ----------------------------------------------------------------------------
module tb
  import tmfc_pkg::*;
;

  // codes the package leaves unnamed
  localparam logic [1:0] OP_UNUSED     = 2'd3;
  localparam logic [2:0] FT_OTHER      = 3'd4;
  localparam logic [2:0] FT_OTHER_LAST = 3'd7;
  localparam logic [1:0] MODE_BAD_LO   = 2'd2;
  localparam logic [1:0] MODE_BAD_HI   = 2'd3;

  localparam int TOTAL_REQUESTS = 1950;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        cfg_we    = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_wdata = '0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  tmfc_in_t    in_data   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  tmfc_out_t   out_data;

  int fail_count;
  int outstanding;
  int sender_idle_pct = 32;
  int recv_idle_pct   = 76;
  int requests_sent   = 0;

  always #4 clk = ~clk;

  telemetry_memory_frame_collector dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  collector_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // Receiver back-pressure: a fresh coin flip every cycle at the current rate.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Offer one request and hold it until the block takes it. in_valid is left
  // high on return; the next call or the next drain decides what it does, so
  // it never gets two assignments in one time step.
  task automatic send_request(input logic [1:0] op, input logic [2:0] ft,
                              input logic [7:0] data);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{opcode: op, frame_type: ft, frame_data: data};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    requests_sent++;
  endtask

  // Stop offering and wait for every predicted report to come out. Every
  // request yields a report, so an empty queue means the block is idle.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Registers only change with nothing in flight. A collection may still be
  // armed, which is how mid-collection changes get exercised.
  task automatic program_regs(input tmfc_cfg_t c);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_PROTOCOL_MODE;
    cfg_wdata <= 16'(c.protocol_mode);
    @(posedge clk);
    cfg_index <= CFG_EXPECTED_BYTES;
    cfg_wdata <= c.expected_bytes;
    @(posedge clk);
    cfg_index <= CFG_TIMEOUT_LIMIT;
    cfg_wdata <= 16'(c.timeout_limit);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Mostly small byte counts and short timeouts so sessions actually finish;
  // zero and full-scale values show up now and then.
  function automatic tmfc_cfg_t pick_settings();
    tmfc_cfg_t c;
    int        r;
    r = $urandom_range(99);
    if (r < 65)      c.protocol_mode = MODE_TOLERANT;
    else if (r < 88) c.protocol_mode = MODE_STRICT;
    else if (r < 94) c.protocol_mode = MODE_BAD_LO;
    else             c.protocol_mode = MODE_BAD_HI;
    r = $urandom_range(99);
    if (r < 6)       c.expected_bytes = 16'd0;
    else if (r < 11) c.expected_bytes = 16'hFFFF;
    else             c.expected_bytes = 16'($urandom_range(1, 12));
    r = $urandom_range(99);
    if (r < 8)       c.timeout_limit = 8'd0;
    else if (r < 14) c.timeout_limit = 8'hFF;
    else             c.timeout_limit = 8'($urandom_range(1, 3));
    return c;
  endfunction

  // One random session: new settings, usually a start, a little leading junk,
  // then a run of memory frames mixed with ticks, tolerated frames and the
  // odd interrupting frame, stray start or unused opcode.
  task automatic run_session();
    tmfc_cfg_t c;
    int        len;
    int        tick_pct;
    int        tol_pct;
    int        r;
    c = pick_settings();
    program_regs(c);
    len      = $urandom_range(4, 40);
    tick_pct = $urandom_range(0, 40);
    tol_pct  = (c.protocol_mode == MODE_TOLERANT) ? $urandom_range(0, 30) : $urandom_range(0, 4);
    if ($urandom_range(9) != 0) begin
      send_request(OP_START, 3'($urandom), 8'($urandom));
    end
    repeat ($urandom_range(0, 2)) begin
      send_request(OP_FRAME, 3'($urandom_range(FT_HS_REQ, FT_OTHER_LAST)), 8'($urandom));
    end
    repeat (len) begin
      r = $urandom_range(99);
      if (r < tick_pct) begin
        send_request(OP_TICK, 3'($urandom), 8'($urandom));
      end else if (r < tick_pct + tol_pct) begin
        send_request(OP_FRAME, 3'($urandom_range(FT_HS_REQ, FT_HS_CONF)), 8'($urandom));
      end else if (r < tick_pct + tol_pct + 3) begin
        send_request(OP_FRAME, 3'($urandom_range(FT_OTHER, FT_OTHER_LAST)), 8'($urandom));
      end else if (r < tick_pct + tol_pct + 5) begin
        send_request(OP_START, 3'($urandom), 8'($urandom));
      end else if (r < tick_pct + tol_pct + 7) begin
        send_request(OP_UNUSED, 3'($urandom), 8'($urandom));
      end else begin
        send_request(OP_FRAME, FT_MEMORY, 8'($urandom));
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed corner cases --------------------------------------------
    program_regs('{protocol_mode: MODE_TOLERANT, expected_bytes: 16'd3, timeout_limit: 8'd1});
    send_request(OP_FRAME, FT_MEMORY, 8'hFF);       // frame while idle
    send_request(OP_TICK, FT_MEMORY, 8'h00);        // tick while idle
    send_request(OP_UNUSED, FT_OTHER_LAST, 8'hFF);  // unused opcode
    send_request(OP_START, FT_MEMORY, 8'h00);
    send_request(OP_FRAME, FT_MEMORY, 8'h00);
    send_request(OP_FRAME, FT_HS_REQ, 8'h11);       // tolerated frames
    send_request(OP_FRAME, FT_MARKER, 8'h22);
    send_request(OP_FRAME, FT_HS_CONF, 8'h33);
    send_request(OP_FRAME, FT_MEMORY, 8'hFF);
    send_request(OP_START, FT_MEMORY, 8'h00);       // restart while armed
    send_request(OP_FRAME, FT_MEMORY, 8'hA5);
    send_request(OP_FRAME, FT_MEMORY, 8'h5A);
    send_request(OP_FRAME, FT_MEMORY, 8'h3C);       // byte count reached
    send_request(OP_START, FT_MEMORY, 8'h00);
    send_request(OP_TICK, FT_MEMORY, 8'h00);        // one tick, well under ten
    // strict mode: any non-memory frame interrupts
    program_regs('{protocol_mode: MODE_STRICT, expected_bytes: 16'hFFFF, timeout_limit: 8'hFF});
    send_request(OP_START, FT_MEMORY, 8'h00);
    send_request(OP_FRAME, FT_MEMORY, 8'h12);
    send_request(OP_FRAME, FT_HS_REQ, 8'h34);
    send_request(OP_START, FT_MEMORY, 8'h00);
    send_request(OP_FRAME, FT_MEMORY, 8'h56);
    // byte count lowered to what was already collected
    program_regs('{protocol_mode: MODE_STRICT, expected_bytes: 16'd1, timeout_limit: 8'hFF});
    send_request(OP_FRAME, FT_MEMORY, 8'h78);
    // zero byte count: error when tolerant, success when strict
    program_regs('{protocol_mode: MODE_TOLERANT, expected_bytes: 16'd0, timeout_limit: 8'd0});
    send_request(OP_START, FT_MEMORY, 8'h00);
    program_regs('{protocol_mode: MODE_STRICT, expected_bytes: 16'd0, timeout_limit: 8'd0});
    send_request(OP_START, FT_MEMORY, 8'h00);
    // invalid mode wins over the zero byte count
    program_regs('{protocol_mode: MODE_BAD_HI, expected_bytes: 16'd0, timeout_limit: 8'd0});
    send_request(OP_START, FT_MEMORY, 8'h00);
    // other frame types and a zero timeout limit
    program_regs('{protocol_mode: MODE_TOLERANT, expected_bytes: 16'd5, timeout_limit: 8'd0});
    send_request(OP_START, FT_MEMORY, 8'h00);
    send_request(OP_FRAME, FT_OTHER_LAST, 8'h9C);   // ignored before first memory
    send_request(OP_FRAME, FT_MEMORY, 8'hC3);
    send_request(OP_FRAME, FT_OTHER, 8'h0F);        // interrupts even when tolerant
    send_request(OP_START, FT_MEMORY, 8'h00);
    send_request(OP_TICK, FT_MEMORY, 8'h00);        // first tick expires

    // --- random sessions, three idle profiles -------------------------------
    while (requests_sent < TOTAL_REQUESTS / 3) run_session();
    sender_idle_pct = 76;
    recv_idle_pct   = 32;
    while (requests_sent < 2 * TOTAL_REQUESTS / 3) run_session();
    sender_idle_pct = 0;
    recv_idle_pct   = 0;
    while (requests_sent < TOTAL_REQUESTS) run_session();

    // wait out the last reports, then keep the clock running for anything stray
    drain();
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("telemetry_memory_frame_collector regression: pass");
    end else begin
      $display("telemetry_memory_frame_collector regression: fail");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("telemetry_memory_frame_collector regression: fail");
    $finish;
  end

endmodule

@@ telemetry_memory_frame_collector.f @@
design/tmfc_pkg.sv
design/tmfc_step.sv
design/telemetry_memory_frame_collector.sv
design/tmfc_checker.sv
sim/collector_checker.sv
sim/tb.sv
